@@ src/avhp_pkg.sv @@
// Shared types, constants and helper functions for the configuration record parser.
package avhp_pkg;

   localparam int unsigned MAX_SET_BYTES    = 512;
   localparam int unsigned MAX_RECORD_BYTES = 4096;
   localparam int unsigned POS_W            = $clog2(MAX_RECORD_BYTES + 1);

   localparam logic [POS_W-1:0] AVC_SIZE_POS   = POS_W'(4);
   localparam logic [POS_W-1:0] AVC_COUNT_POS  = POS_W'(5);
   localparam logic [POS_W-1:0] HEVC_SIZE_POS  = POS_W'(21);
   localparam logic [POS_W-1:0] HEVC_COUNT_POS = POS_W'(22);
   localparam logic [POS_W-1:0] MIN_LAST_POS   = POS_W'(22);
   localparam logic [POS_W-1:0] MAX_POS        = POS_W'(MAX_RECORD_BYTES);
   localparam logic [15:0]      MAX_SET_LEN    = 16'(MAX_SET_BYTES);

   localparam logic [7:0] SIZE_MASK  = 8'h03;
   localparam logic [7:0] COUNT_MASK = 8'h1F;
   localparam logic [7:0] TYPE_MASK  = 8'h3F;

   localparam logic [5:0] UNIT_VPS = 6'd32;
   localparam logic [5:0] UNIT_SPS = 6'd33;
   localparam logic [5:0] UNIT_PPS = 6'd34;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_VPS  = 2'd1,
      KIND_SPS  = 2'd2,
      KIND_PPS  = 2'd3
   } set_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_OVERRUN  = 2'd2,
      STATUS_MISSING  = 2'd3
   } status_type;

   typedef enum logic [9:0] {
      PH_HDR        = 10'b00_0000_0001,
      PH_LEN_HI     = 10'b00_0000_0010,
      PH_LEN_LO     = 10'b00_0000_0100,
      PH_DATA_FIRST = 10'b00_0000_1000,
      PH_DATA       = 10'b00_0001_0000,
      PH_PPS_COUNT  = 10'b00_0010_0000,
      PH_ARR_TYPE   = 10'b00_0100_0000,
      PH_CNT_HI     = 10'b00_1000_0000,
      PH_CNT_LO     = 10'b01_0000_0000,
      PH_TRAIL      = 10'b10_0000_0000
   } phase_type;

   // Maps a NAL unit type onto the kind of parameter set it carries.
   function automatic set_kind_type kind_of(input logic [5:0] unit_type);
      set_kind_type kind;
      kind = KIND_NONE;
      if (unit_type == UNIT_VPS) kind = KIND_VPS;
      if (unit_type == UNIT_SPS) kind = KIND_SPS;
      if (unit_type == UNIT_PPS) kind = KIND_PPS;
      return kind;
   endfunction

   // One bit per kind in the seen mask: bit 0 VPS, bit 1 SPS, bit 2 PPS.
   function automatic logic [2:0] kind_mask(input set_kind_type kind);
      logic [2:0] mask;
      mask = 3'b000;
      unique case (kind)
         KIND_VPS: mask = 3'b001;
         KIND_SPS: mask = 3'b010;
         KIND_PPS: mask = 3'b100;
         default:  mask = 3'b000;
      endcase
      return mask;
   endfunction

endpackage

@@ src/avhp_req_if.sv @@
// Input channel carrying one configuration record byte per transaction.
interface avhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rec_byte;
   logic       rec_last;

   modport source (output valid, output rec_byte, output rec_last, input ready);
   modport sink   (input valid, input rec_byte, input rec_last, output ready);
endinterface

@@ src/avhp_rsp_if.sv @@
// Result channel carrying one tagged byte and record status per transaction.
interface avhp_rsp_if
   import avhp_pkg::*;
;
   logic         valid;
   logic         ready;
   logic [7:0]   out_byte;
   set_kind_type set_kind;
   logic         set_start;
   logic         set_end;
   logic [2:0]   length_field_size;
   logic         record_done;
   status_type   status;

   modport source (output valid, output out_byte, output set_kind, output set_start,
                   output set_end, output length_field_size, output record_done,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input set_kind, input set_start,
                   input set_end, input length_field_size, input record_done,
                   input status, output ready);
endinterface

@@ src/avc_hevc_config_record_parser_core.sv @@
// Top level of the avcC / hvcC decoder configuration record parser.
// A byte accepted on the request channel is captured in the input register; its result
// then moves into the result register and is presented on the result channel.
// Throughput: one transaction per cycle while the result channel is not stalled.
// Reset (synchronous, active high) empties both registers, returns the parser to the
// header phase and clears the codec selection to avcC.
module avc_hevc_config_record_parser_core
   import avhp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   avhp_req_if.sink      req_chan,
   avhp_rsp_if.source    rsp_chan,
   input  logic          csr_write_enable,
   input  logic          csr_write_data
);

   // Codec selection register: 0 parses avcC, 1 parses hvcC.
   logic codec_is_hevc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_is_hevc_ff <= 1'b0;
      end else if (csr_write_enable) begin
         codec_is_hevc_ff <= csr_write_data;
      end
   end

   // Input register. A new transaction is taken whenever this register is empty or
   // its byte moves into the result register in the same cycle, so the parser can still
   // fill an empty input register while a finished result waits on the result channel.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   logic       accept;

   assign advance        = in_valid_ff && (!rsp_chan.valid || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_chan.rec_byte;
         in_last_ff <= req_chan.rec_last;
      end
   end

   // Parse state for the record in progress.
   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        arrays_left_ff, arrays_left_in;
   logic [15:0]       units_left_ff, units_left_in;
   logic [15:0]       set_left_ff, set_left_in;
   logic [5:0]        unit_type_ff, unit_type_in;
   logic              keep_ff, keep_in;
   logic [2:0]        seen_ff, seen_in;
   logic [2:0]        len_size_ff, len_size_in;
   logic              fault_ff, fault_in;

   // Result fields computed from the byte in the input register.
   set_kind_type      kind_now;
   logic              start_now;
   logic              end_now;
   status_type        status_now;

   // Phase to take once an entry or a count is finished: more entries in this list,
   // the next hvcC array, the avcC PPS count after the SPS list, or the trailing bytes.
   function automatic phase_type after_unit(input logic [15:0] units,
                                            input logic [7:0]  arrays,
                                            input logic [5:0]  unit_type,
                                            input logic        hevc);
      phase_type next_phase;
      if (units != 16'd0) begin
         next_phase = PH_LEN_HI;
      end else if (hevc) begin
         next_phase = (arrays != 8'd0) ? PH_ARR_TYPE : PH_TRAIL;
      end else begin
         next_phase = (unit_type == UNIT_SPS) ? PH_PPS_COUNT : PH_TRAIL;
      end
      return next_phase;
   endfunction

   always_comb begin
      logic [POS_W-1:0] size_pos;
      logic [POS_W-1:0] count_pos;
      logic [15:0]      entry_len;
      logic [15:0]      units_dec;
      logic [15:0]      set_dec;
      set_kind_type     entry_kind;
      logic [2:0]       entry_mask;
      logic [2:0]       need_mask;

      phase_in       = phase_ff;
      pos_in         = pos_ff;
      arrays_left_in = arrays_left_ff;
      units_left_in  = units_left_ff;
      set_left_in    = set_left_ff;
      unit_type_in   = unit_type_ff;
      keep_in        = keep_ff;
      seen_in        = seen_ff;
      len_size_in    = len_size_ff;
      fault_in       = fault_ff;
      kind_now       = KIND_NONE;
      start_now      = 1'b0;
      end_now        = 1'b0;
      status_now     = STATUS_OK;

      size_pos   = codec_is_hevc_ff ? HEVC_SIZE_POS : AVC_SIZE_POS;
      count_pos  = codec_is_hevc_ff ? HEVC_COUNT_POS : AVC_COUNT_POS;
      entry_len  = {set_left_ff[15:8], in_byte_ff};
      units_dec  = (units_left_ff != 16'd0) ? units_left_ff - 16'd1 : units_left_ff;
      set_dec    = (set_left_ff != 16'd0) ? set_left_ff - 16'd1 : set_left_ff;
      entry_kind = kind_of(unit_type_ff);
      entry_mask = kind_mask(entry_kind);
      need_mask  = codec_is_hevc_ff ? 3'b111 : 3'b110;

      // The position saturates; any byte at or past the record limit is an overrun.
      if (pos_ff >= MAX_POS) begin
         fault_in = 1'b1;
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end

      unique case (phase_ff)
         PH_HDR: begin
            if (pos_ff == size_pos) begin
               len_size_in = {1'b0, in_byte_ff[1:0] & SIZE_MASK[1:0]} + 3'd1;
            end
            if (pos_ff >= count_pos) begin
               if (codec_is_hevc_ff) begin
                  arrays_left_in = in_byte_ff;
                  phase_in = (in_byte_ff != 8'd0) ? PH_ARR_TYPE : PH_TRAIL;
               end else begin
                  units_left_in = {8'd0, in_byte_ff & COUNT_MASK};
                  unit_type_in  = UNIT_SPS;
                  phase_in = after_unit(units_left_in, arrays_left_ff, UNIT_SPS, 1'b0);
               end
            end
         end
         PH_PPS_COUNT: begin
            units_left_in = {8'd0, in_byte_ff};
            unit_type_in  = UNIT_PPS;
            phase_in = (in_byte_ff != 8'd0) ? PH_LEN_HI : PH_TRAIL;
         end
         PH_ARR_TYPE: begin
            unit_type_in = in_byte_ff[5:0] & TYPE_MASK[5:0];
            if (arrays_left_ff != 8'd0) begin
               arrays_left_in = arrays_left_ff - 8'd1;
            end
            phase_in = PH_CNT_HI;
         end
         PH_CNT_HI: begin
            units_left_in = {in_byte_ff, 8'd0};
            phase_in = PH_CNT_LO;
         end
         PH_CNT_LO: begin
            units_left_in = {units_left_ff[15:8], in_byte_ff};
            phase_in = after_unit(units_left_in, arrays_left_ff, unit_type_ff,
                                  codec_is_hevc_ff);
         end
         PH_LEN_HI: begin
            set_left_in = {in_byte_ff, 8'd0};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            units_left_in = units_dec;
            keep_in = 1'b0;
            // Keep only the first nonempty set of each kind that fits the buffer.
            if (entry_kind != KIND_NONE && entry_len != 16'd0 &&
                entry_len <= MAX_SET_LEN && (seen_ff & entry_mask) == 3'b000) begin
               keep_in = 1'b1;
               seen_in = seen_ff | entry_mask;
            end
            set_left_in = entry_len;
            if (entry_len != 16'd0) begin
               phase_in = PH_DATA_FIRST;
            end else begin
               keep_in  = 1'b0;
               phase_in = after_unit(units_dec, arrays_left_ff, unit_type_ff,
                                     codec_is_hevc_ff);
            end
         end
         PH_DATA_FIRST, PH_DATA: begin
            if (keep_ff) begin
               kind_now  = entry_kind;
               start_now = (phase_ff == PH_DATA_FIRST);
               end_now   = (set_left_ff == 16'd1);
            end
            set_left_in = set_dec;
            if (set_dec == 16'd0) begin
               keep_in  = 1'b0;
               phase_in = after_unit(units_left_ff, arrays_left_ff, unit_type_ff,
                                     codec_is_hevc_ff);
            end else begin
               phase_in = PH_DATA;
            end
         end
         default: begin
            phase_in = PH_TRAIL;
         end
      endcase

      // On the last byte report the status in priority order and start a new record.
      if (in_last_ff) begin
         if (pos_ff < MIN_LAST_POS) begin
            status_now = STATUS_SHORT;
         end else if (fault_in || phase_in == PH_DATA_FIRST || phase_in == PH_DATA) begin
            status_now = STATUS_OVERRUN;
         end else if ((seen_in & need_mask) != need_mask) begin
            status_now = STATUS_MISSING;
         end else begin
            status_now = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR;
         pos_ff         <= '0;
         arrays_left_ff <= '0;
         units_left_ff  <= '0;
         set_left_ff    <= '0;
         unit_type_ff   <= '0;
         keep_ff        <= 1'b0;
         seen_ff        <= '0;
         len_size_ff    <= '0;
         fault_ff       <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            phase_ff       <= PH_HDR;
            pos_ff         <= '0;
            arrays_left_ff <= '0;
            units_left_ff  <= '0;
            set_left_ff    <= '0;
            unit_type_ff   <= '0;
            keep_ff        <= 1'b0;
            seen_ff        <= '0;
            len_size_ff    <= '0;
            fault_ff       <= 1'b0;
         end else begin
            phase_ff       <= phase_in;
            pos_ff         <= pos_in;
            arrays_left_ff <= arrays_left_in;
            units_left_ff  <= units_left_in;
            set_left_ff    <= set_left_in;
            unit_type_ff   <= unit_type_in;
            keep_ff        <= keep_in;
            seen_ff        <= seen_in;
            len_size_ff    <= len_size_in;
            fault_ff       <= fault_in;
         end
      end
   end

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff;
   set_kind_type rsp_kind_ff;
   logic         rsp_start_ff;
   logic         rsp_end_ff;
   logic [2:0]   rsp_size_ff;
   logic         rsp_done_ff;
   status_type   rsp_status_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff   <= in_byte_ff;
         rsp_kind_ff   <= kind_now;
         rsp_start_ff  <= start_now;
         rsp_end_ff    <= end_now;
         rsp_size_ff   <= len_size_in;
         rsp_done_ff   <= in_last_ff;
         rsp_status_ff <= status_now;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.out_byte          = rsp_byte_ff;
   assign rsp_chan.set_kind          = rsp_kind_ff;
   assign rsp_chan.set_start         = rsp_start_ff;
   assign rsp_chan.set_end           = rsp_end_ff;
   assign rsp_chan.length_field_size = rsp_size_ff;
   assign rsp_chan.record_done       = rsp_done_ff;
   assign rsp_chan.status            = rsp_status_ff;

   // A set is only kept while its payload bytes are being walked.
   assert property (@(posedge clock) disable iff (reset)
      keep_ff |-> (phase_ff == PH_DATA_FIRST || phase_ff == PH_DATA))
      else $error("kept set outside of a payload phase");

   // A start or end mark only ever travels with a kept set kind.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_start_ff || rsp_end_ff)) |-> rsp_kind_ff != KIND_NONE)
      else $error("set boundary mark on an untagged byte");

   // A nonzero status is reported only on the last byte of a record.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |-> rsp_status_ff == STATUS_OK)
      else $error("status reported before the end of the record");

   // Finishing a record returns the parser to the start of the header.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (phase_ff == PH_HDR && pos_ff == '0 && seen_ff == 3'b000))
      else $error("parse state not cleared after the last byte");

   // The position counter never passes the record limit.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MAX_POS)
      else $error("byte position beyond saturation");

endmodule
